[src/rrna_pkg.sv]
// Shared widths, register indexes and lane request type for the resize address generator.
package rrna_pkg;

  // Field widths
  localparam int DIM_W = 13;               // dimension registers
  localparam int CRD_W = 12;               // target and source coordinates
  localparam int STR_W = 14;               // row stride register
  localparam int ADR_W = 25;               // linear source address
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 14;

  // Divider: one quotient bit per stage, quotient as wide as a clamped source coordinate
  localparam int QW = DIM_W;
  localparam int NUM_W = 2 * DIM_W + 2;
  localparam int LANE_STAGES = QW + 3;     // product, bound check, QW digits, clamp
  localparam int PROD_W = DIM_W + STR_W;

  localparam int MAX_DIMENSION_DEF = 4096;
  localparam logic [STR_W-1:0] STRIDE_LIMIT = STR_W'(8192);

  // Register reset values
  localparam logic [DIM_W-1:0] SRC_W_RST = DIM_W'(640);
  localparam logic [DIM_W-1:0] SRC_H_RST = DIM_W'(480);
  localparam logic [STR_W-1:0] STRIDE_RST = STR_W'(640);
  localparam logic [DIM_W-1:0] TGT_W_RST = DIM_W'(480);
  localparam logic [DIM_W-1:0] TGT_H_RST = DIM_W'(640);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_ROW_STRIDE    = 3'd2,
    REG_TARGET_WIDTH  = 3'd3,
    REG_TARGET_HEIGHT = 3'd4,
    REG_ROTATION_MODE = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ROT_NONE = 2'd0,
    ROT_90   = 2'd1,
    ROT_180  = 2'd2,
    ROT_270  = 2'd3
  } rot_mode_t;

  // One axis of the mapping: coordinate, span, source maximum, direction
  typedef struct packed {
    logic [CRD_W-1:0] t;
    logic [DIM_W-1:0] d;
    logic [DIM_W-1:0] smax;
    logic             rev;
  } axis_req_t;

endpackage

[src/rrna_axis.sv]
// One axis lane: scaled coordinate, half-up rounding by long division, clamp.
module rrna_axis
  import rrna_pkg::*;
(
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] stage_en,
  input  axis_req_t              req,
  output logic [DIM_W-1:0]       coord
);

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [QW-1:0]    quo;
    logic [DIM_W:0]   dvs;
    logic [DIM_W-1:0] smax;
    logic             ovf;
    logic             zero;
  } div_t;

  // Stage 1: numerator and overflow bound
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [NUM_W-1:0] lim_r, lim_nxt;
  logic [DIM_W-1:0] d1_r, smax1_r;
  logic             zero1_r, zero_nxt;
  logic [DIM_W-1:0] t_ext, t_eff, smax_p1;

  always_comb begin
    t_ext    = DIM_W'(req.t);
    zero_nxt = req.rev && (t_ext > req.d);
    t_eff    = req.rev ? (req.d - t_ext) : t_ext;
    smax_p1  = req.smax + DIM_W'(1);
    num_nxt  = NUM_W'(t_eff) * NUM_W'(req.smax);
    lim_nxt  = NUM_W'({req.d, 1'b0}) * NUM_W'(smax_p1);
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      num_r   <= num_nxt;
      lim_r   <= lim_nxt;
      d1_r    <= req.d;
      smax1_r <= req.smax;
      zero1_r <= zero_nxt;
    end
  end

  // Stage 2: rounding offset and clamp test, q > smax when 2n+d >= 2d(smax+1)
  div_t dv_r   [QW+1];
  div_t dv_nxt [QW+1];

  always_comb begin
    dv_nxt[0].rem  = {num_r[NUM_W-2:0], 1'b0} + NUM_W'(d1_r);
    dv_nxt[0].quo  = '0;
    dv_nxt[0].dvs  = {d1_r, 1'b0};
    dv_nxt[0].smax = smax1_r;
    dv_nxt[0].ovf  = dv_nxt[0].rem >= lim_r;
    dv_nxt[0].zero = zero1_r;
  end

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      dv_r[0] <= dv_nxt[0];
    end
  end

  // Restoring division, most significant quotient bit first
  for (genvar j = 1; j <= QW; j++) begin : g_digit
    localparam int B = QW - j;
    logic [NUM_W-1:0] trial;

    always_comb begin
      dv_nxt[j] = dv_r[j-1];
      trial     = NUM_W'(dv_r[j-1].dvs) << B;
      if (dv_r[j-1].rem >= trial) begin
        dv_nxt[j].rem    = dv_r[j-1].rem - trial;
        dv_nxt[j].quo[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (stage_en[j+1]) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // Clamp: reversed beyond span gives 0, beyond source gives smax
  logic [DIM_W-1:0] coord_r, coord_nxt;

  always_comb begin
    if (dv_r[QW].zero) begin
      coord_nxt = '0;
    end else if (dv_r[QW].ovf) begin
      coord_nxt = dv_r[QW].smax;
    end else begin
      coord_nxt = dv_r[QW].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[QW+2]) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

[src/rotate_resize_nearest_address.sv]
// Top level of the rotated nearest-neighbour resize source address generator.
//
// Usage: configure sizes, stride and rotation through the cfg_ channel (index, data,
// one transfer per register write; cfg_ready is always high) while no pixel is in
// flight. Then send target coordinates on the in_ channel, one transfer per cycle.
// Each input transfer yields exactly one result on the out_ channel: source column,
// source row and linear address row * stride + column, in input order.
// Throughput is one pixel per cycle while the receiver accepts results. The
// pipeline depth is set by the rounding divider, which resolves one
// quotient bit per stage for the 13-bit source coordinate, plus input, product,
// bound check, clamp, stride multiply and output stages.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default sizes
// 640x480 source, 480x640 target, stride 640, no rotation.
// When the receiver stalls the pipeline closes up behind the waiting result; bubbles
// are squeezed out, and in_ready drops only once every stage holds a pixel.
module rotate_resize_nearest_address
  import rrna_pkg::*;
#(
  parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CRD_W-1:0]      in_target_x,
  input  logic [CRD_W-1:0]      in_target_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CRD_W-1:0]      out_source_x,
  output logic [CRD_W-1:0]      out_source_y,
  output logic [ADR_W-1:0]      out_source_address
);

  localparam int NST = LANE_STAGES + 3;    // input, lanes, multiply, output
  localparam logic [31:0] MAX_D = 32'(MAX_DIMENSION);
  localparam logic [DIM_W-1:0] MAX_T = DIM_W'(MAX_DIMENSION);

  // Configuration registers
  logic [DIM_W-1:0] src_w_r, src_h_r, tgt_w_r, tgt_h_r;
  logic [STR_W-1:0] stride_r;
  logic [1:0]       rot_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r  <= SRC_W_RST;
      src_h_r  <= SRC_H_RST;
      stride_r <= STRIDE_RST;
      tgt_w_r  <= TGT_W_RST;
      tgt_h_r  <= TGT_H_RST;
      rot_r    <= ROT_NONE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_WIDTH:  src_w_r  <= cfg_data[DIM_W-1:0];
        REG_SOURCE_HEIGHT: src_h_r  <= cfg_data[DIM_W-1:0];
        REG_ROW_STRIDE:    stride_r <= cfg_data[STR_W-1:0];
        REG_TARGET_WIDTH:  tgt_w_r  <= cfg_data[DIM_W-1:0];
        REG_TARGET_HEIGHT: tgt_h_r  <= cfg_data[DIM_W-1:0];
        REG_ROTATION_MODE: rot_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Saturated sizes, registered from the configuration registers
  logic [DIM_W-1:0] sw_m1_r, sh_m1_r, dw_r, dh_r;
  logic [DIM_W-1:0] sw_m1_nxt, sh_m1_nxt, dw_nxt, dh_nxt;
  logic [STR_W-1:0] str_sat_r, str_sat_nxt;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] lo);
    logic [DIM_W-1:0] res;
    if (v < lo) begin
      res = lo;
    end else if (32'(v) > MAX_D) begin
      res = MAX_T;
    end else begin
      res = v;
    end
    return res;
  endfunction

  always_comb begin
    sw_m1_nxt   = sat_dim(src_w_r, DIM_W'(1)) - DIM_W'(1);
    sh_m1_nxt   = sat_dim(src_h_r, DIM_W'(1)) - DIM_W'(1);
    dw_nxt      = sat_dim(tgt_w_r, DIM_W'(2)) - DIM_W'(1);
    dh_nxt      = sat_dim(tgt_h_r, DIM_W'(2)) - DIM_W'(1);
    str_sat_nxt = (stride_r > STRIDE_LIMIT) ? STRIDE_LIMIT : stride_r;
  end

  always_ff @(posedge clk) begin
    sw_m1_r   <= sw_m1_nxt;
    sh_m1_r   <= sh_m1_nxt;
    dw_r      <= dw_nxt;
    dh_r      <= dh_nxt;
    str_sat_r <= str_sat_nxt;
  end

  // Stage valids and per-stage advance: a stage moves when the output is taken or any stage at or after it is empty
  logic [NST-1:0] v_r;
  logic [NST-1:0] en;

  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = out_ready || !(&v_r[NST-1:k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ready = en[0];

  // Stage 0: input register
  logic [CRD_W-1:0] tx_r, ty_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tx_r <= in_target_x;
      ty_r <= in_target_y;
    end
  end

  // Rotation picks coordinate, span and direction for each source axis
  axis_req_t req_x, req_y;

  always_comb begin
    req_x.smax = sw_m1_r;
    req_y.smax = sh_m1_r;
    case (rot_r)
      ROT_90: begin
        req_x.t = ty_r; req_x.d = dh_r; req_x.rev = 1'b0;
        req_y.t = tx_r; req_y.d = dw_r; req_y.rev = 1'b1;
      end
      ROT_180: begin
        req_x.t = tx_r; req_x.d = dw_r; req_x.rev = 1'b1;
        req_y.t = ty_r; req_y.d = dh_r; req_y.rev = 1'b1;
      end
      ROT_270: begin
        req_x.t = ty_r; req_x.d = dh_r; req_x.rev = 1'b1;
        req_y.t = tx_r; req_y.d = dw_r; req_y.rev = 1'b0;
      end
      default: begin
        req_x.t = tx_r; req_x.d = dw_r; req_x.rev = 1'b0;
        req_y.t = ty_r; req_y.d = dh_r; req_y.rev = 1'b0;
      end
    endcase
  end

  logic [DIM_W-1:0] sx_lane, sy_lane;

  rrna_axis u_axis_x (
    .clk      (clk),
    .stage_en (en[LANE_STAGES:1]),
    .req      (req_x),
    .coord    (sx_lane)
  );

  rrna_axis u_axis_y (
    .clk      (clk),
    .stage_en (en[LANE_STAGES:1]),
    .req      (req_y),
    .coord    (sy_lane)
  );

  // Row offset multiply
  logic [PROD_W-1:0] prod_r;
  logic [DIM_W-1:0]  mx_r, my_r;

  always_ff @(posedge clk) begin
    if (en[NST-2]) begin
      prod_r <= PROD_W'(sy_lane) * PROD_W'(str_sat_r);
      mx_r   <= sx_lane;
      my_r   <= sy_lane;
    end
  end

  // Output register: column add and field masks
  logic [CRD_W-1:0] ox_r, oy_r;
  logic [ADR_W-1:0] oa_r;
  logic [PROD_W-1:0] addr_full;

  assign addr_full = prod_r + PROD_W'(mx_r);

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      ox_r <= mx_r[CRD_W-1:0];
      oy_r <= my_r[CRD_W-1:0];
      oa_r <= addr_full[ADR_W-1:0];
    end
  end

  assign out_valid          = v_r[NST-1];
  assign out_source_x       = ox_r;
  assign out_source_y       = oy_r;
  assign out_source_address = oa_r;

  // Input back-pressure arises only from a full pipeline behind a stalled result
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("in_ready low without a stalled result");

  // Reset empties the pipeline
  a_reset_flush : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

endmodule
